>>> hw/rtl/aor_pkg.sv
// Shared types and codes for the address range overlap registry.
`default_nettype none
package aor_pkg;

  localparam int unsigned AddrW    = 64;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned EntriesW = 5;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 3'd0,
    STATUS_ZERO    = 3'd1,
    STATUS_NULL    = 3'd2,
    STATUS_OVERLAP = 3'd3,
    STATUS_FULL    = 3'd4,
    STATUS_WRAP    = 3'd5
  } status_e;

  // Query travelling down the cell row.
  typedef struct packed {
    logic             vld;
    logic [AddrW-1:0] first;
    logic [AddrW-1:0] last;
    logic             hit;
  } query_t;

  // Broadcast table write.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] first;
    logic [AddrW-1:0] last;
  } wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/aor_cell.sv
// One table entry plus one stage of the overlap scan pipeline.
`default_nettype none
module aor_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire aor_pkg::wr_t    wr_i,
  input  wire logic [CntW-1:0] wr_idx_i,
  input  wire aor_pkg::query_t q_i,
  output aor_pkg::query_t      q_o
);
  import aor_pkg::*;

  logic             entry_vld_q;
  logic [AddrW-1:0] first_q;
  logic [AddrW-1:0] last_q;
  logic             q_vld_q;
  logic [AddrW-1:0] q_first_q;
  logic [AddrW-1:0] q_last_q;
  logic             q_hit_q;
  logic             wr_sel;
  logic             match;

  assign wr_sel = wr_i.en && (wr_idx_i == CntW'(Idx));
  // closed-interval test on inclusive bounds: any shared byte
  assign match  = entry_vld_q && (q_i.first <= last_q) && (first_q <= q_i.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
      q_vld_q     <= 1'b0;
    end else begin
      if (clear_i) begin
        entry_vld_q <= 1'b0;
      end else if (wr_sel) begin
        entry_vld_q <= 1'b1;
      end
      q_vld_q <= q_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      first_q <= wr_i.first;
      last_q  <= wr_i.last;
    end
    q_first_q <= q_i.first;
    q_last_q  <= q_i.last;
    q_hit_q   <= q_i.hit | match;
  end

  assign q_o = '{vld: q_vld_q, first: q_first_q, last: q_last_q, hit: q_hit_q};

endmodule
`default_nettype wire

>>> hw/rtl/address_range_overlap_registry.sv
// Top level of the address range overlap registry.
`default_nettype none
// Records up to MAX_REGIONS byte regions, each kept as inclusive first/last
// addresses in a row of cells. A check item (opcode 0) is rejected with zero
// size, null start or wrap status straight away; otherwise its bounds are sent
// down the cell row, one cell per cycle, each cell OR-ing in its own overlap
// hit. At the end of the row the item gets overlap, full or ok, and an ok
// region is written into the next free cell. A clear item (opcode 1)
// drops every entry and answers ok with zero entries. A clear or an early
// reject answers in the cycle after acceptance; a region that reaches the
// table answers once it has passed the launch register, every cell of the
// row and the scan and resolve states. One item is in flight at a time; the
// next is taken once the result register is free or being drained.
// entries_used is the entry count cut to 5 bits.
module address_range_overlap_registry #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      opcode_i,
  input  wire logic [aor_pkg::AddrW-1:0] region_start_i,
  input  wire logic [aor_pkg::AddrW-1:0] region_size_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [aor_pkg::StatusW-1:0]    status_o,
  output logic [aor_pkg::EntriesW-1:0]   entries_used_o
);
  import aor_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_e;

  state_e           state_q, state_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             launch_q, launch_d;
  logic             hit_q, hit_d;
  logic [AddrW-1:0] first_q, last_q;

  logic             accept;
  logic             out_free;
  logic [AddrW-1:0] size_m1;
  logic [AddrW-1:0] last_calc;
  logic             is_wrap;
  logic             clear;
  wr_t              wr;
  query_t           chain [MAX_REGIONS+1];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign clear      = accept && (opcode_i == OP_CLEAR);

  // Wrap when size-1 exceeds the room left above start.
  assign size_m1   = region_size_i - AddrW'(1);
  assign last_calc = region_start_i + size_m1;
  assign is_wrap   = size_m1 > ~region_start_i;

  assign chain[0] = '{vld: launch_q, first: first_q, last: last_q, hit: 1'b0};

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    aor_cell #(
      .CntW(CntW),
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .wr_i    (wr),
      .wr_idx_i(count_q),
      .q_i     (chain[i]),
      .q_o     (chain[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    count_d     = count_q;
    launch_d    = 1'b0;
    hit_d       = hit_q;
    wr          = '{en: 1'b0, first: first_q, last: last_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_CLEAR) begin
            count_d     = '0;
            status_d    = STATUS_OK;
            out_valid_d = 1'b1;
          end else if (region_size_i == '0) begin
            status_d    = STATUS_ZERO;
            out_valid_d = 1'b1;
          end else if (region_start_i == '0) begin
            status_d    = STATUS_NULL;
            out_valid_d = 1'b1;
          end else if (is_wrap) begin
            status_d    = STATUS_WRAP;
            out_valid_d = 1'b1;
          end else begin
            launch_d = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // result drops out of the last cell
        if (chain[MAX_REGIONS].vld) begin
          hit_d   = chain[MAX_REGIONS].hit;
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (hit_q) begin
            status_d = STATUS_OVERLAP;
          end else if (count_q >= CntW'(MAX_REGIONS)) begin
            status_d = STATUS_FULL;
          end else begin
            status_d = STATUS_OK;
            wr.en    = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      count_q     <= '0;
      launch_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      count_q     <= count_d;
      launch_q    <= launch_d;
      hit_q       <= hit_d;
    end
  end

  // query bounds, held for the scan and for the table write
  always_ff @(posedge clk_i) begin
    if (launch_d) begin
      first_q <= region_start_i;
      last_q  <= last_calc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entries_used_o = EntriesW'(count_q);

endmodule
`default_nettype wire

>>> hw/rtl/aor_checker.sv
// Port-level checks for the address range overlap registry, with its bind.
`default_nettype none
module aor_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      opcode_i,
  input wire logic [aor_pkg::AddrW-1:0] region_start_i,
  input wire logic [aor_pkg::AddrW-1:0] region_size_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [aor_pkg::StatusW-1:0]  status_o,
  input wire logic [aor_pkg::EntriesW-1:0] entries_used_o
);
  import aor_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_clear_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CLEAR) |=>
      out_valid_o && (status_o == STATUS_OK) && (entries_used_o == '0))
    else $error("clear did not answer ok with empty table");

  a_zero_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CHECK) && (region_size_i == '0) |=>
      out_valid_o && (status_o == STATUS_ZERO))
    else $error("zero size not reported");

  a_null_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CHECK) && (region_size_i != '0) &&
      (region_start_i == '0) |=> out_valid_o && (status_o == STATUS_NULL))
    else $error("null start not reported");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(entries_used_o))
    else $error("result changed while stalled");

endmodule

bind address_range_overlap_registry aor_checker u_aor_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .opcode_i      (opcode_i),
  .region_start_i(region_start_i),
  .region_size_i (region_size_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .entries_used_o(entries_used_o)
);
`default_nettype wire
